>>> rtl/ntriples_line_tokenizer_top_assert.svh
// assertion macros used by the tokenizer top
// clocked on clk, disabled while rst_n is low
`ifndef NTRIPLES_LINE_TOKENIZER_TOP_ASSERT_SVH
`define NTRIPLES_LINE_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTH
`define NTLT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NTLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NTLT_ASSERT_IMPL(lbl, ante, cons, msg)
`define NTLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/ntlt_pkg.sv
package ntlt_pkg;

    localparam int LINE_W         = 32;
    localparam int CFG_W          = 16;
    localparam logic [CFG_W-1:0] MAX_TERM_LEN_RST = 16'd4096;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'd0,
        MODE_QUOTE   = 4'd1,
        MODE_BRACKET = 4'd2,
        MODE_BLANK   = 4'd3,
        MODE_ESCAPE  = 4'd4,
        MODE_CARET1  = 4'd5,
        MODE_CARET2  = 4'd6,
        MODE_COMMENT = 4'd7,
        MODE_AFTER   = 4'd8
    } mode_t;

    typedef enum logic [3:0] {
        ERR_NONE          = 4'd0,
        ERR_BACKSLASH_END = 4'd1,
        ERR_OPEN_QUOTE    = 4'd2,
        ERR_OPEN_BRACKET  = 4'd3,
        ERR_BLANK_EOL     = 4'd4,
        ERR_STRAY_CARET   = 4'd5,
        ERR_OPEN_CARET    = 4'd6,
        ERR_NO_PERIOD     = 4'd7,
        ERR_JUNK          = 4'd8,
        ERR_EARLY_EOL     = 4'd9,
        ERR_UNEXPECTED    = 4'd10,
        ERR_TOO_LONG      = 4'd11
    } err_t;

    typedef struct packed {
        logic              char_valid;
        logic [7:0]        char_value;
        logic [1:0]        term_index;
        logic              term_end;
        logic              triple_done;
        logic              finished;
        err_t              error_code;
        logic [LINE_W-1:0] line_number;
        logic              last_result;
    } ntlt_res_t;

    typedef struct packed {
        logic [1:0] n;
        ntlt_res_t  r0;
        ntlt_res_t  r1;
    } ntlt_push_t;

    function automatic ntlt_res_t mk_res(
        input logic              cv,
        input logic [7:0]        ch,
        input logic [1:0]        ti,
        input logic              te,
        input logic              td,
        input logic              fin,
        input err_t              err,
        input logic [LINE_W-1:0] line
    );
        ntlt_res_t r;
        r.char_valid  = cv;
        r.char_value  = ch;
        r.term_index  = ti;
        r.term_end    = te;
        r.triple_done = td;
        r.finished    = fin;
        r.error_code  = err;
        r.line_number = line;
        r.last_result = 1'b0;
        return r;
    endfunction

endpackage

>>> rtl/ntlt_core.sv
module ntlt_core #(
    parameter int TERM_LEN_BITS   = 16,
    parameter int LINE_COUNT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic [7:0]                          in_byte,
    input  logic                                end_of_input,
    input  logic [ntlt_pkg::CFG_W-1:0]          max_term_len,
    output ntlt_pkg::ntlt_push_t                push
);
    import ntlt_pkg::*;

    localparam int CMP_W = (TERM_LEN_BITS > CFG_W) ? TERM_LEN_BITS : CFG_W;

    mode_t                      mode_reg, mode_next;
    mode_t                      esc_ret_reg, esc_ret_next;
    logic [1:0]                 terms_reg, terms_next;
    logic                       skip_reg, skip_next;
    logic                       start_reg, start_next;
    logic                       content_reg, content_next;
    logic                       period_reg, period_next;
    logic [TERM_LEN_BITS-1:0]   term_len_reg, term_len_next;
    logic [LINE_COUNT_BITS-1:0] line_cnt_reg, line_cnt_next;
    logic                       stopped_reg, stopped_next;
    err_t                       stop_code_reg, stop_code_next;

    logic [TERM_LEN_BITS-1:0]   len_plus;
    logic [LINE_COUNT_BITS-1:0] line_inc;
    logic [LINE_W-1:0]          line_cur_out, line_inc_out;
    logic                       fit0, fit1;
    ntlt_res_t                  res0, res1;
    logic [1:0]                 n_res;

    assign len_plus = term_len_reg + 1'b1;
    assign line_inc = (line_cnt_reg == '1) ? line_cnt_reg : line_cnt_reg + 1'b1;

    // room for one more byte, and for a second one after it
    assign fit0 = (CMP_W'(term_len_reg) < CMP_W'(max_term_len)) && (term_len_reg != '1);
    assign fit1 = (CMP_W'(len_plus) < CMP_W'(max_term_len)) && (len_plus != '1);

    generate
        if (LINE_COUNT_BITS > LINE_W) begin : g_line_cap
            assign line_cur_out = (|line_cnt_reg[LINE_COUNT_BITS-1:LINE_W]) ?
                                  '1 : line_cnt_reg[LINE_W-1:0];
            assign line_inc_out = (|line_inc[LINE_COUNT_BITS-1:LINE_W]) ?
                                  '1 : line_inc[LINE_W-1:0];
        end
        else begin : g_line_ext
            assign line_cur_out = LINE_W'(line_cnt_reg);
            assign line_inc_out = LINE_W'(line_inc);
        end
    endgenerate

    always_comb
    begin
        logic       eoi;
        logic       do_norm;
        logic       is_blank;
        logic       hold;
        logic [7:0] nb;

        mode_next      = mode_reg;
        esc_ret_next   = esc_ret_reg;
        terms_next     = terms_reg;
        skip_next      = skip_reg;
        start_next     = start_reg;
        content_next   = content_reg;
        period_next    = period_reg;
        term_len_next  = term_len_reg;
        line_cnt_next  = line_cnt_reg;
        stopped_next   = stopped_reg;
        stop_code_next = stop_code_reg;
        res0           = '0;
        res1           = '0;
        n_res          = 2'd0;
        do_norm        = 1'b0;
        nb             = in_byte;
        is_blank       = 1'b0;
        hold           = 1'b0;
        eoi            = end_of_input || (in_byte == CH_NUL);

        if (stopped_reg)
        begin
            res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, stop_code_reg == ERR_NONE,
                           stop_code_reg, line_cur_out);
            n_res = 2'd1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_ESCAPE:
                begin
                    if (eoi)
                    begin
                        stopped_next   = 1'b1;
                        stop_code_next = ERR_BACKSLASH_END;
                        res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                       ERR_BACKSLASH_END, line_cur_out);
                        n_res = 2'd1;
                    end
                    else
                    begin
                        mode_next    = esc_ret_reg;
                        content_next = 1'b1;
                        if (fit0)
                        begin
                            res0  = mk_res(1'b1, CH_BSLASH, terms_reg, 1'b0, 1'b0, 1'b0,
                                           ERR_NONE, line_cur_out);
                            n_res = 2'd2;
                            if (fit1)
                            begin
                                term_len_next = term_len_reg + 2'd2;
                                res1 = mk_res(1'b1, in_byte, terms_reg, 1'b0, 1'b0, 1'b0,
                                              ERR_NONE, line_cur_out);
                            end
                            else
                            begin
                                term_len_next  = len_plus;
                                stopped_next   = 1'b1;
                                stop_code_next = ERR_TOO_LONG;
                                res1 = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                              ERR_TOO_LONG, line_cur_out);
                            end
                        end
                        else
                        begin
                            stopped_next   = 1'b1;
                            stop_code_next = ERR_TOO_LONG;
                            res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                           ERR_TOO_LONG, line_cur_out);
                            n_res = 2'd1;
                        end
                    end
                end
                MODE_CARET1:
                begin
                    if (eoi || in_byte != CH_CARET)
                    begin
                        stopped_next   = 1'b1;
                        stop_code_next = ERR_STRAY_CARET;
                        res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                       ERR_STRAY_CARET, line_cur_out);
                        n_res = 2'd1;
                    end
                    else
                    begin
                        mode_next = MODE_CARET2;
                    end
                end
                MODE_CARET2:
                begin
                    // datatype suffix runs up to the next space
                    if (eoi)
                    begin
                        stopped_next   = 1'b1;
                        stop_code_next = ERR_OPEN_CARET;
                        res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                       ERR_OPEN_CARET, line_cur_out);
                        n_res = 2'd1;
                    end
                    else if (in_byte == CH_SPACE)
                    begin
                        mode_next = MODE_NORMAL;
                        do_norm   = 1'b1;
                        nb        = CH_SPACE;
                    end
                end
                MODE_COMMENT:
                begin
                    if (eoi)
                    begin
                        line_cnt_next  = line_inc;
                        stopped_next   = 1'b1;
                        stop_code_next = ERR_NONE;
                        res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b1,
                                       ERR_NONE, line_inc_out);
                        n_res = 2'd1;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        line_cnt_next = line_inc;
                        mode_next     = MODE_NORMAL;
                    end
                end
                MODE_AFTER:
                begin
                    if (eoi || in_byte == CH_LF)
                    begin
                        if (!period_reg)
                        begin
                            stopped_next   = 1'b1;
                            stop_code_next = ERR_NO_PERIOD;
                            res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                           ERR_NO_PERIOD, line_cur_out);
                            n_res = 2'd1;
                        end
                        else
                        begin
                            res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b1, 1'b0,
                                           ERR_NONE, line_cur_out);
                            n_res = 2'd1;
                            line_cnt_next = line_inc;
                            terms_next    = 2'd0;
                            start_next    = 1'b1;
                            skip_next     = 1'b1;
                            content_next  = 1'b0;
                            period_next   = 1'b0;
                            term_len_next = '0;
                            mode_next     = MODE_NORMAL;
                            if (eoi)
                            begin
                                stopped_next   = 1'b1;
                                stop_code_next = ERR_NONE;
                                res1  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b1,
                                               ERR_NONE, line_inc_out);
                                n_res = 2'd2;
                            end
                        end
                    end
                    else if (in_byte == CH_SPACE || in_byte == CH_TAB)
                    begin
                        hold = 1'b0;
                    end
                    else if (in_byte == CH_DOT && !period_reg)
                    begin
                        period_next = 1'b1;
                    end
                    else
                    begin
                        stopped_next   = 1'b1;
                        stop_code_next = ERR_JUNK;
                        res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                       ERR_JUNK, line_cur_out);
                        n_res = 2'd1;
                    end
                end
                MODE_NORMAL, MODE_QUOTE, MODE_BRACKET, MODE_BLANK:
                begin
                    if (eoi)
                    begin
                        stopped_next   = 1'b1;
                        stop_code_next = ERR_NONE;
                        res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b1,
                                       ERR_NONE, line_cur_out);
                        n_res = 2'd1;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        esc_ret_next = mode_reg;
                        mode_next    = MODE_ESCAPE;
                    end
                    else if (mode_reg == MODE_QUOTE || mode_reg == MODE_BRACKET)
                    begin
                        if (in_byte == CH_LF)
                        begin
                            stopped_next   = 1'b1;
                            stop_code_next = (mode_reg == MODE_QUOTE) ?
                                             ERR_OPEN_QUOTE : ERR_OPEN_BRACKET;
                            res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                           stop_code_next, line_cur_out);
                            n_res = 2'd1;
                        end
                        else if (fit0)
                        begin
                            term_len_next = len_plus;
                            res0  = mk_res(1'b1, in_byte, terms_reg, 1'b0, 1'b0, 1'b0,
                                           ERR_NONE, line_cur_out);
                            n_res = 2'd1;
                            if ((mode_reg == MODE_QUOTE && in_byte == CH_QUOTE) ||
                                (mode_reg == MODE_BRACKET && in_byte == CH_GT))
                            begin
                                mode_next = MODE_NORMAL;
                            end
                        end
                        else
                        begin
                            stopped_next   = 1'b1;
                            stop_code_next = ERR_TOO_LONG;
                            res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                           ERR_TOO_LONG, line_cur_out);
                            n_res = 2'd1;
                        end
                    end
                    else if (mode_reg == MODE_BLANK)
                    begin
                        if (in_byte == CH_LF)
                        begin
                            stopped_next   = 1'b1;
                            stop_code_next = ERR_BLANK_EOL;
                            res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                           ERR_BLANK_EOL, line_cur_out);
                            n_res = 2'd1;
                        end
                        else if (in_byte != CH_SPACE)
                        begin
                            if (fit0)
                            begin
                                term_len_next = len_plus;
                                res0  = mk_res(1'b1, in_byte, terms_reg, 1'b0, 1'b0, 1'b0,
                                               ERR_NONE, line_cur_out);
                                n_res = 2'd1;
                            end
                            else
                            begin
                                stopped_next   = 1'b1;
                                stop_code_next = ERR_TOO_LONG;
                                res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                               ERR_TOO_LONG, line_cur_out);
                                n_res = 2'd1;
                            end
                        end
                        else
                        begin
                            mode_next = MODE_NORMAL;
                            do_norm   = 1'b1;
                            nb        = CH_SPACE;
                        end
                    end
                    else
                    begin
                        do_norm = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase

            // byte handling outside any term
            if (do_norm)
            begin
                is_blank = (nb == CH_SPACE) || (nb == CH_TAB);
                if (nb == CH_CARET)
                begin
                    mode_next = MODE_CARET1;
                end
                else
                begin
                    if (skip_reg)
                    begin
                        if (is_blank)
                        begin
                            hold = 1'b1;
                        end
                        else if (nb == CH_HASH && start_reg)
                        begin
                            mode_next = MODE_COMMENT;
                            hold      = 1'b1;
                        end
                        else
                        begin
                            start_next = 1'b0;
                            skip_next  = 1'b0;
                        end
                    end
                    if (!hold)
                    begin
                        if (is_blank || (nb == CH_DOT && terms_reg >= 2'd2))
                        begin
                            skip_next = 1'b1;
                            res0  = mk_res(1'b0, 8'h00, terms_reg, 1'b1, 1'b0, 1'b0,
                                           ERR_NONE, line_cur_out);
                            n_res = 2'd1;
                            if (terms_reg >= 2'd2)
                            begin
                                mode_next   = MODE_AFTER;
                                period_next = (nb == CH_DOT);
                            end
                            else
                            begin
                                terms_next = terms_reg + 1'b1;
                            end
                            term_len_next = '0;
                        end
                        else if (nb == CH_QUOTE || nb == CH_LT || nb == CH_UNDER)
                        begin
                            if (fit0)
                            begin
                                term_len_next = len_plus;
                                res0  = mk_res(1'b1, nb, terms_reg, 1'b0, 1'b0, 1'b0,
                                               ERR_NONE, line_cur_out);
                                n_res = 2'd1;
                                content_next = 1'b1;
                                if (nb == CH_QUOTE)
                                    mode_next = MODE_QUOTE;
                                else if (nb == CH_LT)
                                    mode_next = MODE_BRACKET;
                                else
                                    mode_next = MODE_BLANK;
                            end
                            else
                            begin
                                stopped_next   = 1'b1;
                                stop_code_next = ERR_TOO_LONG;
                                res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                               ERR_TOO_LONG, line_cur_out);
                                n_res = 2'd1;
                            end
                        end
                        else if (nb == CH_LF)
                        begin
                            if (content_reg)
                            begin
                                stopped_next   = 1'b1;
                                stop_code_next = ERR_EARLY_EOL;
                                res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                               ERR_EARLY_EOL, line_cur_out);
                                n_res = 2'd1;
                            end
                            else
                            begin
                                line_cnt_next = line_inc;
                                skip_next     = 1'b1;
                                start_next    = 1'b1;
                            end
                        end
                        else
                        begin
                            stopped_next   = 1'b1;
                            stop_code_next = ERR_UNEXPECTED;
                            res0  = mk_res(1'b0, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0,
                                           ERR_UNEXPECTED, line_cur_out);
                            n_res = 2'd1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        push.n              = n_res;
        push.r0             = res0;
        push.r0.last_result = (n_res == 2'd1);
        push.r1             = res1;
        push.r1.last_result = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            esc_ret_reg   <= MODE_NORMAL;
            terms_reg     <= 2'd0;
            skip_reg      <= 1'b1;
            start_reg     <= 1'b1;
            content_reg   <= 1'b0;
            period_reg    <= 1'b0;
            term_len_reg  <= '0;
            line_cnt_reg  <= LINE_COUNT_BITS'(1);
            stopped_reg   <= 1'b0;
            stop_code_reg <= ERR_NONE;
        end
        else if (take)
        begin
            mode_reg      <= mode_next;
            esc_ret_reg   <= esc_ret_next;
            terms_reg     <= terms_next;
            skip_reg      <= skip_next;
            start_reg     <= start_next;
            content_reg   <= content_next;
            period_reg    <= period_next;
            term_len_reg  <= term_len_next;
            line_cnt_reg  <= line_cnt_next;
            stopped_reg   <= stopped_next;
            stop_code_reg <= stop_code_next;
        end
    end

endmodule

>>> rtl/ntriples_line_tokenizer_top.sv
// N-Triples line tokenizer
// s_axis: one text byte per beat, tdata[7:0] the byte, tlast marks end of input
// (a zero byte also ends the input). m_axis: one result per beat, a term byte,
// a term end, a triple done, a finish or an error mark, each with the line number;
// tlast flags the last result caused by an input byte. cfg: write of the term
// length limit, taken in any cycle, to be written only while the block is idle.
// A byte's results are registered into the output queue as the byte is taken.
// Throughput: one byte per cycle while m_axis is not stalled and each byte gives
// at most one result; two results (an escape, a final triple) drop s_axis_tready.
// The figure is set by the single-pass state update and the three-entry output
// queue, which takes a byte whenever at least two entries are free.
// A stalled m_axis fills the queue and then drops s_axis_tready; nothing is lost.
// After an error or a finish every further byte repeats that mark until reset.
// Reset (rst_n low, asynchronous) empties the queue, restores the limit to 4096
// and starts at line 1 in the normal scan state; no clearing pass follows.
`include "ntriples_line_tokenizer_top_assert.svh"
module ntriples_line_tokenizer_top #(
    parameter int TERM_LEN_BITS   = 16,
    parameter int LINE_COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // char_value, error_code, line_number, zero pad
    output logic [5:0]  m_axis_tuser,   // char_valid, term_index, term_end, triple_done,
                                        // finished
    output logic        m_axis_tlast,   // last_result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data        // max_term_len
);
    import ntlt_pkg::*;

    localparam int QDEPTH = 3;

    logic [CFG_W-1:0] max_len_reg;
    ntlt_push_t       push;
    ntlt_res_t        q_reg  [QDEPTH];
    ntlt_res_t        q_next [QDEPTH];
    logic [1:0]       cnt_reg, cnt_next;
    logic [1:0]       base;
    logic [1:0]       n_push;
    logic             acc;
    logic             pop;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (cnt_reg < 2'd2);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    ntlt_core #(
        .TERM_LEN_BITS   (TERM_LEN_BITS),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (acc),
        .in_byte      (s_axis_tdata),
        .end_of_input (s_axis_tlast),
        .max_term_len (max_len_reg),
        .push         (push)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_TERM_LEN_RST;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= cfg_data;
    end

    // output queue: head at entry 0, shifts down on each beat taken
    assign n_push   = acc ? push.n : 2'd0;
    assign base     = cnt_reg - {1'b0, pop};
    assign cnt_next = cnt_reg - {1'b0, pop} + n_push;

    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_next[i] = q_reg[i];
            if (pop && (i < QDEPTH - 1))
                q_next[i] = q_reg[(i < QDEPTH - 1) ? i + 1 : i];
            if (n_push != 2'd0 && base == 2'(i))
                q_next[i] = push.r0;
            if (n_push == 2'd2 && (base + 1'b1) == 2'(i))
                q_next[i] = push.r1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    assign m_axis_tdata = {4'b0000, q_reg[0].line_number, q_reg[0].error_code,
                           q_reg[0].char_value};
    assign m_axis_tuser = {q_reg[0].finished, q_reg[0].triple_done, q_reg[0].term_end,
                           q_reg[0].term_index, q_reg[0].char_valid};
    assign m_axis_tlast = q_reg[0].last_result;

    `NTLT_ASSERT_IMPL(a_stop_last, m_axis_tvalid && (m_axis_tdata[11:8] != ERR_NONE || m_axis_tuser[5]), m_axis_tlast, "error or finish beat not last of its byte")
    `NTLT_ASSERT_IMPL(a_char_clean, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[11:8] == ERR_NONE && m_axis_tuser[2:1] != 2'd3 && !m_axis_tuser[5], "term byte beat carries a bad mark")
    `NTLT_ASSERT_IMPL(a_no_overflow, acc, (3'(cnt_reg) - 3'(pop) + 3'(push.n)) <= 3'(QDEPTH), "output queue overflow")
    `NTLT_ASSERT_NEXT(a_pair_shown, acc && push.n == 2'd2, m_axis_tvalid && cnt_reg != 2'd0, "result pair not queued")
    `NTLT_ASSERT_IMPL(a_marks_apart, m_axis_tvalid, !(m_axis_tuser[3] && m_axis_tuser[4]), "term end and triple done on one beat")

endmodule
